### design/icpf_pkg.sv
// ----------------------------------------------------------------------------
// icpf_pkg
// Shared types and constants of the image corner point finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package icpf_pkg;

  // red level that marks a white pixel
  localparam logic [7:0] WHITE_LEVEL = 8'd255;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

  // entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned NUM_CORNERS = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROOT,
    BK_APPLY
  } back_state_t;

endpackage

`default_nettype wire

### design/image_corner_point_finder.sv
// A white pixel holds the back end while the four square root units produce one root
//   bit a cycle; any other pixel goes straight to the update. The back end takes the
//   next queue entry only once it is idle again.
// Reset (synchronous, rst_n low): both registers and radii to all ones, coordinates
//   to zero, queue empty. A four-entry queue buffers bursts; results cannot stall.
// ----------------------------------------------------------------------------
// image_corner_point_finder
// Finds, over one frame, the white pixel nearest each of the four image
// corners and reports their coordinates on the last pixel of the frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module image_corner_point_finder #(
  parameter int unsigned COORD_WIDTH = 12
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  output logic                                 busy,
  input  wire  [COORD_WIDTH-1:0]               in_pixel_x,
  input  wire  [COORD_WIDTH-1:0]               in_pixel_y,
  input  wire  [7:0]                           in_red_level,
  input  wire                                  in_frame_end,
  output logic                                 out_valid,
  output logic [COORD_WIDTH-1:0]               out_top_left_x,
  output logic [COORD_WIDTH-1:0]               out_top_left_y,
  output logic [COORD_WIDTH-1:0]               out_top_right_x,
  output logic [COORD_WIDTH-1:0]               out_top_right_y,
  output logic [COORD_WIDTH-1:0]               out_bottom_right_x,
  output logic [COORD_WIDTH-1:0]               out_bottom_right_y,
  output logic [COORD_WIDTH-1:0]               out_bottom_left_x,
  output logic [COORD_WIDTH-1:0]               out_bottom_left_y,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [icpf_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [COORD_WIDTH-1:0]               cfg_wdata
);

  localparam int unsigned NC        = icpf_pkg::NUM_CORNERS;
  localparam int unsigned PAY_WIDTH = 2 * COORD_WIDTH + 2 + 4 * (2 * COORD_WIDTH + 1);

  logic [COORD_WIDTH-1:0]  width_r, width_nxt, height_r, height_nxt;
  logic                    reload_r, reload_nxt;
  icpf_pkg::queue_status_t q_status;
  logic                    push, pop;
  logic [PAY_WIDTH-1:0]    push_data, pop_data;
  logic [COORD_WIDTH-1:0]  res_x [NC];
  logic [COORD_WIDTH-1:0]  res_y [NC];

  always_comb begin
    cfg_ready  = 1'b1;
    width_nxt  = width_r;
    height_nxt = height_r;
    reload_nxt = 1'b0;
    if (cfg_valid) begin
      if (cfg_index == icpf_pkg::REG_IMAGE_WIDTH) begin
        width_nxt  = cfg_wdata;
        reload_nxt = 1'b1;
      end else if (cfg_index == icpf_pkg::REG_IMAGE_HEIGHT) begin
        height_nxt = cfg_wdata;
      end
    end
  end

  // radii reload through the registered reload flag, from the updated width register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= '1;
      height_r <= '1;
      reload_r <= 1'b0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      reload_r <= reload_nxt;
    end
  end

  icpf_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .PAY_WIDTH   (PAY_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .pixel_x      (in_pixel_x),
    .pixel_y      (in_pixel_y),
    .red_level    (in_red_level),
    .frame_end    (in_frame_end),
    .image_width  (width_r),
    .image_height (height_r),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  icpf_queue #(
    .WIDTH (PAY_WIDTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  icpf_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .PAY_WIDTH   (PAY_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_status      (q_status),
    .q_data        (pop_data),
    .pop           (pop),
    .image_width   (width_r),
    .radius_reload (reload_r),
    .out_valid     (out_valid),
    .out_x         (res_x),
    .out_y         (res_y)
  );

  // corner order: (0,0), (W,0), (W,H), (0,H)
  always_comb begin
    out_top_left_x     = res_x[0];
    out_top_left_y     = res_y[0];
    out_top_right_x    = res_x[1];
    out_top_right_y    = res_y[1];
    out_bottom_right_x = res_x[2];
    out_bottom_right_y = res_y[2];
    out_bottom_left_x  = res_x[3];
    out_bottom_left_y  = res_y[3];
  end

endmodule

`default_nettype wire

### design/icpf_front.sv
// ----------------------------------------------------------------------------
// icpf_front
// Accepts pixels, flags white ones and forms the squared distance to each of
// the four corners, then pushes the entry into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module icpf_front #(
  parameter int unsigned COORD_WIDTH = 12,
  parameter int unsigned PAY_WIDTH   = 2 * COORD_WIDTH + 2 + 4 * (2 * COORD_WIDTH + 1)
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  output logic                        busy,
  input  wire  [COORD_WIDTH-1:0]      pixel_x,
  input  wire  [COORD_WIDTH-1:0]      pixel_y,
  input  wire  [7:0]                  red_level,
  input  wire                         frame_end,
  input  wire  [COORD_WIDTH-1:0]      image_width,
  input  wire  [COORD_WIDTH-1:0]      image_height,
  input  icpf_pkg::queue_status_t     q_status,
  output logic                        push,
  output logic [PAY_WIDTH-1:0]        push_data
);

  localparam int unsigned SQW = 2 * COORD_WIDTH;
  localparam int unsigned DW  = SQW + 1;

  logic                   s1_valid_r, s1_valid_nxt;
  logic [SQW-1:0]         sq_x_r, sq_y_r, sq_wx_r, sq_hy_r;
  logic [SQW-1:0]         sq_x_nxt, sq_y_nxt, sq_wx_nxt, sq_hy_nxt;
  logic [COORD_WIDTH-1:0] x_r, y_r;
  logic                   white_r, last_r;
  logic [COORD_WIDTH-1:0] diff_wx, diff_hy;
  logic [DW-1:0]          d2_0, d2_1, d2_2, d2_3;
  logic                   accept;

  always_comb begin
    push         = s1_valid_r && !q_status.full;
    busy         = s1_valid_r && q_status.full;
    accept       = start && !busy;
    s1_valid_nxt = accept ? 1'b1 : (push ? 1'b0 : s1_valid_r);

    // pixels outside the frame take the absolute difference, so it is squared exactly
    diff_wx = (image_width >= pixel_x) ? (image_width - pixel_x) : (pixel_x - image_width);
    diff_hy = (image_height >= pixel_y) ? (image_height - pixel_y) : (pixel_y - image_height);

    sq_x_nxt  = SQW'(pixel_x) * SQW'(pixel_x);
    sq_y_nxt  = SQW'(pixel_y) * SQW'(pixel_y);
    sq_wx_nxt = SQW'(diff_wx) * SQW'(diff_wx);
    sq_hy_nxt = SQW'(diff_hy) * SQW'(diff_hy);

    d2_0 = {1'b0, sq_x_r}  + {1'b0, sq_y_r};
    d2_1 = {1'b0, sq_wx_r} + {1'b0, sq_y_r};
    d2_2 = {1'b0, sq_wx_r} + {1'b0, sq_hy_r};
    d2_3 = {1'b0, sq_x_r}  + {1'b0, sq_hy_r};

    push_data = {d2_3, d2_2, d2_1, d2_0, y_r, x_r, last_r, white_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_x_r  <= sq_x_nxt;
      sq_y_r  <= sq_y_nxt;
      sq_wx_r <= sq_wx_nxt;
      sq_hy_r <= sq_hy_nxt;
      x_r     <= pixel_x;
      y_r     <= pixel_y;
      white_r <= (red_level == icpf_pkg::WHITE_LEVEL);
      last_r  <= frame_end;
    end
  end

endmodule

`default_nettype wire

### design/icpf_queue.sv
// ----------------------------------------------------------------------------
// icpf_queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module icpf_queue #(
  parameter int unsigned WIDTH = 102
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      push,
  input  wire  [WIDTH-1:0]         push_data,
  input  wire                      pop,
  output logic [WIDTH-1:0]         pop_data,
  output icpf_pkg::queue_status_t  status
);

  localparam int unsigned DEPTH = icpf_pkg::QUEUE_DEPTH;
  localparam int unsigned PTRW  = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTRW-1:0]  wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [PTRW:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  always_comb begin
    status.full  = (count_r == (PTRW+1)'(DEPTH));
    status.empty = (count_r == '0);
    do_push      = push && !status.full;
    do_pop       = pop && !status.empty;
    wr_ptr_nxt   = do_push ? PTRW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt   = do_pop ? PTRW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt    = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
    pop_data = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    status.full |-> !push)
    else $error("queue pushed while full");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    status.empty |-> !pop)
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

### design/icpf_back.sv
// ----------------------------------------------------------------------------
// icpf_back
// Takes entries from the queue, finds for white pixels the integer square root of the four
// squared distances one result bit a cycle, updates the corner radii and
// coordinates, and emits the kept coordinates at the end of a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module icpf_back #(
  parameter int unsigned COORD_WIDTH = 12,
  parameter int unsigned PAY_WIDTH   = 2 * COORD_WIDTH + 2 + 4 * (2 * COORD_WIDTH + 1)
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  icpf_pkg::queue_status_t     q_status,
  input  wire  [PAY_WIDTH-1:0]        q_data,
  output logic                        pop,
  input  wire  [COORD_WIDTH-1:0]      image_width,
  input  wire                         radius_reload,
  output logic                        out_valid,
  output logic [COORD_WIDTH-1:0]      out_x [icpf_pkg::NUM_CORNERS],
  output logic [COORD_WIDTH-1:0]      out_y [icpf_pkg::NUM_CORNERS]
);

  localparam int unsigned NC   = icpf_pkg::NUM_CORNERS;
  localparam int unsigned DW   = 2 * COORD_WIDTH + 1;
  localparam int unsigned RW   = COORD_WIDTH + 1;
  localparam int unsigned VW   = 2 * RW;
  localparam int unsigned TW   = RW + 2;
  localparam int unsigned CNTW = $clog2(RW);

  icpf_pkg::back_state_t  state_r, state_nxt;
  logic [CNTW-1:0]        cnt_r, cnt_nxt;
  logic [VW-1:0]          val_r [NC], val_nxt [NC];
  logic [TW-1:0]          rem_r [NC], rem_nxt [NC];
  logic [RW-1:0]          root_r [NC], root_nxt [NC];
  logic [COORD_WIDTH-1:0] radius_r [NC], radius_nxt [NC];
  logic [COORD_WIDTH-1:0] cx_r [NC], cx_nxt [NC];
  logic [COORD_WIDTH-1:0] cy_r [NC], cy_nxt [NC];
  logic [COORD_WIDTH-1:0] x_r, x_nxt, y_r, y_nxt;
  logic                   white_r, white_nxt, last_r, last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [COORD_WIDTH-1:0] out_x_r [NC], out_x_nxt [NC];
  logic [COORD_WIDTH-1:0] out_y_r [NC], out_y_nxt [NC];
  logic [TW-1:0]          tmp [NC], trial [NC];
  logic                   take;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    white_nxt     = white_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    pop           = 1'b0;
    take          = 1'b0;
    for (int k = 0; k < NC; k++) begin
      val_nxt[k]    = val_r[k];
      rem_nxt[k]    = rem_r[k];
      root_nxt[k]   = root_r[k];
      radius_nxt[k] = radius_r[k];
      cx_nxt[k]     = cx_r[k];
      cy_nxt[k]     = cy_r[k];
      out_x_nxt[k]  = out_x_r[k];
      out_y_nxt[k]  = out_y_r[k];
      // bring down the next two bits and try the next root bit
      tmp[k]   = {rem_r[k][TW-3:0], val_r[k][VW-1 -: 2]};
      trial[k] = {root_r[k], 2'b01};
    end

    case (state_r)
      icpf_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          pop       = 1'b1;
          white_nxt = q_data[0];
          last_nxt  = q_data[1];
          x_nxt     = q_data[2 +: COORD_WIDTH];
          y_nxt     = q_data[2 + COORD_WIDTH +: COORD_WIDTH];
          for (int k = 0; k < NC; k++) begin
            val_nxt[k]  = {1'b0, q_data[2 + 2 * COORD_WIDTH + k * DW +: DW]};
            rem_nxt[k]  = '0;
            root_nxt[k] = '0;
          end
          cnt_nxt   = '0;
          state_nxt = q_data[0] ? icpf_pkg::BK_ROOT : icpf_pkg::BK_APPLY;
        end
      end
      icpf_pkg::BK_ROOT: begin
        for (int k = 0; k < NC; k++) begin
          if (tmp[k] >= trial[k]) begin
            rem_nxt[k]  = tmp[k] - trial[k];
            root_nxt[k] = {root_r[k][RW-2:0], 1'b1};
          end else begin
            rem_nxt[k]  = tmp[k];
            root_nxt[k] = {root_r[k][RW-2:0], 1'b0};
          end
          val_nxt[k] = {val_r[k][VW-3:0], 2'b00};
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(RW - 1)) begin
          state_nxt = icpf_pkg::BK_APPLY;
        end
      end
      icpf_pkg::BK_APPLY: begin
        // d2 < m*m holds exactly when floor(sqrt(d2)) < m
        for (int k = 0; k < NC; k++) begin
          take = white_r && ({1'b0, radius_r[k]} > root_r[k]);
          if (take) begin
            radius_nxt[k] = root_r[k][COORD_WIDTH-1:0];
            cx_nxt[k]     = x_r;
            cy_nxt[k]     = y_r;
          end
          if (last_r) begin
            out_x_nxt[k]  = cx_nxt[k];
            out_y_nxt[k]  = cy_nxt[k];
            radius_nxt[k] = image_width;
            cx_nxt[k]     = '0;
            cy_nxt[k]     = '0;
          end
        end
        out_valid_nxt = last_r;
        state_nxt     = icpf_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = icpf_pkg::BK_IDLE;
      end
    endcase

    if (radius_reload) begin
      for (int k = 0; k < NC; k++) begin
        radius_nxt[k] = image_width;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= icpf_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NC; k++) begin
        radius_r[k] <= '1;
        cx_r[k]     <= '0;
        cy_r[k]     <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < NC; k++) begin
        radius_r[k] <= radius_nxt[k];
        cx_r[k]     <= cx_nxt[k];
        cy_r[k]     <= cy_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    x_r     <= x_nxt;
    y_r     <= y_nxt;
    white_r <= white_nxt;
    last_r  <= last_nxt;
    for (int k = 0; k < NC; k++) begin
      val_r[k]   <= val_nxt[k];
      rem_r[k]   <= rem_nxt[k];
      root_r[k]  <= root_nxt[k];
      out_x_r[k] <= out_x_nxt[k];
      out_y_r[k] <= out_y_nxt[k];
    end
  end

  always_comb begin
    out_valid = out_valid_r;
    for (int k = 0; k < NC; k++) begin
      out_x[k] = out_x_r[k];
      out_y[k] = out_y_r[k];
    end
  end

`ifndef ASSERT_OFF
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_root_white: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == icpf_pkg::BK_ROOT) |-> white_r)
    else $error("root iteration on a non-white pixel");

  a_emit_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_nxt |-> (state_r == icpf_pkg::BK_APPLY) && last_r)
    else $error("result emitted outside the frame end");
`endif

endmodule

`default_nettype wire

### sim/tb_image_corner_point_finder.sv
// ----------------------------------------------------------------------------
// tb_image_corner_point_finder
// Self-checking bench for the corner point finder. Frames of pixels are sent
// through the start/busy port with random gaps. A scoreboard tracks each
// corner's radius and kept pixel and queues the coordinates due at each frame
// end, and every strobed result is compared with the oldest entry. Frame size
// is changed between phases, and the width now and then in the middle of a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_image_corner_point_finder;

  localparam int CW = 12;
  localparam int TOTAL_PIXELS = 1975;
  localparam int DRAIN_CYCLES = 2 * ((icpf_pkg::QUEUE_DEPTH + 2) * (CW + 4));
  localparam int CYCLE_LIMIT = 1000000;

  localparam int TOP_LEFT     = 0;
  localparam int TOP_RIGHT    = 1;
  localparam int BOTTOM_RIGHT = 2;
  localparam int BOTTOM_LEFT  = 3;

  // x then y of each corner, top left in the low slot
  typedef logic [2*icpf_pkg::NUM_CORNERS-1:0][CW-1:0] corner_coords_t;

  class corner_scoreboard;
    logic [CW-1:0] frame_w;
    logic [CW-1:0] frame_h;
    logic [12:0] radius [icpf_pkg::NUM_CORNERS];
    logic [CW-1:0] kept_x [icpf_pkg::NUM_CORNERS];
    logic [CW-1:0] kept_y [icpf_pkg::NUM_CORNERS];
    corner_coords_t frame_results_q [$];
    int unsigned error_count;

    function new();
      frame_w = '1;
      frame_h = '1;
      error_count = 0;
      restart_frame();
    endfunction

    function void restart_frame();
      for (int k = 0; k < icpf_pkg::NUM_CORNERS; k++) begin
        radius[k] = {1'b0, frame_w};
        kept_x[k] = '0;
        kept_y[k] = '0;
      end
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 15; b >= 0; b--) begin
        t = r | (longint'(1) << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    function void note_config(logic [icpf_pkg::CFG_INDEX_W-1:0] idx, logic [CW-1:0] val);
      if (idx == icpf_pkg::REG_IMAGE_WIDTH) begin
        frame_w = val;
        for (int k = 0; k < icpf_pkg::NUM_CORNERS; k++) radius[k] = {1'b0, val};
      end else if (idx == icpf_pkg::REG_IMAGE_HEIGHT) begin
        frame_h = val;
      end
    endfunction

    function void note_pixel(logic [CW-1:0] x, logic [CW-1:0] y, logic [7:0] red,
                             logic last);
      longint dx;
      longint dy;
      longint dist2;
      corner_coords_t coords;
      if (red == icpf_pkg::WHITE_LEVEL) begin
        for (int k = 0; k < icpf_pkg::NUM_CORNERS; k++) begin
          dx = longint'(x) - ((k == TOP_RIGHT || k == BOTTOM_RIGHT) ? longint'(frame_w) : 0);
          dy = longint'(y) - ((k == BOTTOM_RIGHT || k == BOTTOM_LEFT) ? longint'(frame_h) : 0);
          dist2 = dx * dx + dy * dy;
          if (dist2 < longint'(radius[k]) * longint'(radius[k])) begin
            radius[k] = 13'(root_floor(dist2));
            kept_x[k] = x;
            kept_y[k] = y;
          end
        end
      end
      if (last) begin
        for (int k = 0; k < icpf_pkg::NUM_CORNERS; k++) begin
          coords[2*k] = kept_x[k];
          coords[2*k+1] = kept_y[k];
        end
        frame_results_q.push_back(coords);
        restart_frame();
      end
    endfunction

    function string coord_name(int i);
      case (i)
        0: return "top_left_x";
        1: return "top_left_y";
        2: return "top_right_x";
        3: return "top_right_y";
        4: return "bottom_right_x";
        5: return "bottom_right_y";
        6: return "bottom_left_x";
        default: return "bottom_left_y";
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      error_count++;
    endtask

    task check_result(corner_coords_t got);
      corner_coords_t want;
      if (frame_results_q.size() == 0) begin
        report("result strobe with no frame end pending");
        return;
      end
      want = frame_results_q.pop_front();
      for (int i = 0; i < 2 * icpf_pkg::NUM_CORNERS; i++) begin
        if (got[i] !== want[i])
          report($sformatf("%s got %0d want %0d", coord_name(i), got[i], want[i]));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [CW-1:0] in_pixel_x;
  logic [CW-1:0] in_pixel_y;
  logic [7:0] in_red_level;
  logic in_frame_end;
  logic out_valid;
  logic [CW-1:0] out_top_left_x;
  logic [CW-1:0] out_top_left_y;
  logic [CW-1:0] out_top_right_x;
  logic [CW-1:0] out_top_right_y;
  logic [CW-1:0] out_bottom_right_x;
  logic [CW-1:0] out_bottom_right_y;
  logic [CW-1:0] out_bottom_left_x;
  logic [CW-1:0] out_bottom_left_y;
  logic cfg_valid;
  logic cfg_ready;
  logic [icpf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [CW-1:0] cfg_wdata;

  corner_scoreboard sb;
  int unsigned pixels_sent;
  int unsigned cycle_count;

  image_corner_point_finder #(
    .COORD_WIDTH(CW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_pixel_x(in_pixel_x),
    .in_pixel_y(in_pixel_y),
    .in_red_level(in_red_level),
    .in_frame_end(in_frame_end),
    .out_valid(out_valid),
    .out_top_left_x(out_top_left_x),
    .out_top_left_y(out_top_left_y),
    .out_top_right_x(out_top_right_x),
    .out_top_right_y(out_top_right_y),
    .out_bottom_right_x(out_bottom_right_x),
    .out_bottom_right_y(out_bottom_right_y),
    .out_bottom_left_x(out_bottom_left_x),
    .out_bottom_left_y(out_bottom_left_y),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1)
      sb.check_result({out_bottom_left_y, out_bottom_left_x,
                       out_bottom_right_y, out_bottom_right_x,
                       out_top_right_y, out_top_right_x,
                       out_top_left_y, out_top_left_x});
  end

  task automatic send_pixel(input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input logic [7:0] red, input logic last, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    in_red_level <= red;
    in_frame_end <= last;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_pixel(x, y, red, last);
    pixels_sent++;
  endtask

  // stop sending, let every frame result arrive, then let the queue drain
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.frame_results_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [icpf_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [CW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.note_config(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic directed_frames();
    // nothing white: all corners stay at zero
    send_pixel(12'd10, 12'd10, 8'd254, 1'b0, $urandom_range(0, 10));
    send_pixel(12'd4095, 12'd0, 8'd0, 1'b0, $urandom_range(0, 10));
    send_pixel(12'd0, 12'd0, 8'd0, 1'b1, $urandom_range(0, 10));
    // pixels right on each corner, a tie that must not replace the first
    send_pixel(12'd0, 12'd0, icpf_pkg::WHITE_LEVEL, 1'b0, $urandom_range(0, 10));
    send_pixel(12'd0, 12'd0, icpf_pkg::WHITE_LEVEL, 1'b0, $urandom_range(0, 10));
    send_pixel(12'd4095, 12'd0, icpf_pkg::WHITE_LEVEL, 1'b0, $urandom_range(0, 10));
    send_pixel(12'd4095, 12'd4095, icpf_pkg::WHITE_LEVEL, 1'b0, $urandom_range(0, 10));
    send_pixel(12'd0, 12'd4095, icpf_pkg::WHITE_LEVEL, 1'b0, $urandom_range(0, 10));
    send_pixel(12'd2048, 12'd2048, icpf_pkg::WHITE_LEVEL, 1'b1, $urandom_range(0, 10));
    // width rewrite mid-frame reloads the radii, so a farther pixel wins
    send_pixel(12'd100, 12'd100, icpf_pkg::WHITE_LEVEL, 1'b0, $urandom_range(0, 10));
    wait_idle();
    write_reg(icpf_pkg::REG_IMAGE_WIDTH, 12'd4095);
    send_pixel(12'd200, 12'd200, icpf_pkg::WHITE_LEVEL, 1'b1, $urandom_range(0, 10));
    // unknown indexes are ignored; then pixels outside a small frame
    wait_idle();
    write_reg(4'd15, 12'hfff);
    write_reg(4'd2, 12'd7);
    write_reg(icpf_pkg::REG_IMAGE_WIDTH, 12'd100);
    write_reg(icpf_pkg::REG_IMAGE_HEIGHT, 12'd50);
    send_pixel(12'd4095, 12'd4095, icpf_pkg::WHITE_LEVEL, 1'b0, $urandom_range(0, 10));
    send_pixel(12'd0, 12'd0, icpf_pkg::WHITE_LEVEL, 1'b0, $urandom_range(0, 10));
    send_pixel(12'd50, 12'd25, icpf_pkg::WHITE_LEVEL, 1'b1, $urandom_range(0, 10));
    // zero width: nothing is ever taken
    wait_idle();
    write_reg(icpf_pkg::REG_IMAGE_WIDTH, 12'd0);
    send_pixel(12'd0, 12'd0, icpf_pkg::WHITE_LEVEL, 1'b0, $urandom_range(0, 10));
    send_pixel(12'd4095, 12'd4095, icpf_pkg::WHITE_LEVEL, 1'b1, $urandom_range(0, 10));
    wait_idle();
    write_reg(icpf_pkg::REG_IMAGE_WIDTH, 12'd1);
    write_reg(icpf_pkg::REG_IMAGE_HEIGHT, 12'd1);
    send_pixel(12'd0, 12'd0, icpf_pkg::WHITE_LEVEL, 1'b0, $urandom_range(0, 10));
    send_pixel(12'd1, 12'd1, icpf_pkg::WHITE_LEVEL, 1'b0, $urandom_range(0, 10));
    send_pixel(12'd1, 12'd0, icpf_pkg::WHITE_LEVEL, 1'b0, $urandom_range(0, 10));
    send_pixel(12'd0, 12'd1, icpf_pkg::WHITE_LEVEL, 1'b1, $urandom_range(0, 10));
    // single-pixel frames
    wait_idle();
    write_reg(icpf_pkg::REG_IMAGE_WIDTH, 12'd4095);
    write_reg(icpf_pkg::REG_IMAGE_HEIGHT, 12'd4095);
    send_pixel(12'd4095, 12'd4095, icpf_pkg::WHITE_LEVEL, 1'b1, $urandom_range(0, 10));
    send_pixel(12'd0, 12'd0, icpf_pkg::WHITE_LEVEL, 1'b1, $urandom_range(0, 10));
  endtask

  task automatic send_frame(input int len, input bit burst, input bit rewrite_mid);
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [7:0] red;
    for (int i = 0; i < len; i++) begin
      if (rewrite_mid && i == len / 2 && len > 1) begin
        wait_idle();
        write_reg(icpf_pkg::REG_IMAGE_WIDTH, CW'($urandom_range(0, 4095)));
      end
      red = ($urandom_range(0, 99) < 55) ? icpf_pkg::WHITE_LEVEL
                                         : 8'($urandom_range(0, 254));
      // mostly inside the frame, some anywhere in the coordinate range
      x = ($urandom_range(0, 4) == 0) ? CW'($urandom_range(0, 4095))
                                      : CW'($urandom_range(0, sb.frame_w));
      y = ($urandom_range(0, 4) == 0) ? CW'($urandom_range(0, 4095))
                                      : CW'($urandom_range(0, sb.frame_h));
      send_pixel(x, y, red, i == len - 1, burst ? 0 : $urandom_range(0, 10));
    end
  endtask

  task automatic random_phases();
    int phase;
    int frames;
    logic [CW-1:0] w;
    logic [CW-1:0] h;
    phase = 0;
    while (pixels_sent < TOTAL_PIXELS) begin
      case (phase)
        0: begin w = 12'd4095; h = 12'd4095; end
        1: begin w = 12'd1;    h = 12'd1;    end
        2: begin w = 12'd0;    h = 12'd4095; end
        3: begin w = 12'd4095; h = 12'd1;    end
        4: begin w = 12'd1;    h = 12'd4095; end
        default: begin
          w = ($urandom_range(0, 3) == 0) ? CW'($urandom_range(1, 40))
                                          : CW'($urandom_range(1, 4095));
          h = ($urandom_range(0, 3) == 0) ? CW'($urandom_range(1, 40))
                                          : CW'($urandom_range(1, 4095));
        end
      endcase
      wait_idle();
      if ($urandom_range(0, 1) == 0) begin
        write_reg(icpf_pkg::REG_IMAGE_WIDTH, w);
        write_reg(icpf_pkg::REG_IMAGE_HEIGHT, h);
      end else begin
        write_reg(icpf_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(icpf_pkg::REG_IMAGE_WIDTH, w);
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(icpf_pkg::CFG_INDEX_W'($urandom_range(2, 15)), CW'($urandom()));
      frames = $urandom_range(2, 6);
      for (int f = 0; f < frames && pixels_sent < TOTAL_PIXELS; f++) begin
        send_frame($urandom_range(1, 50), $urandom_range(0, 2) == 0,
                   $urandom_range(0, 9) == 0);
        if ($urandom_range(0, 7) == 0) wait_idle();
      end
      phase++;
    end
  endtask

  initial begin
    sb = new();
    pixels_sent = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_pixel_x = '0;
    in_pixel_y = '0;
    in_red_level = '0;
    in_frame_end = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    directed_frames();
    random_phases();
    wait_idle();

    if (sb.error_count == 0 && sb.frame_results_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
